>>> sv/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define WIC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define WIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WIC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)

`define WIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> sv/wic_pkg.sv
`default_nettype none

package wic_pkg;

    localparam int unsigned TIMER_W    = 16;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned WAIT_W     = 12;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [TIMER_W-1:0] TIMER_IDLE     = 16'd65534;
    localparam logic [TIMER_W-1:0] LEARN_MIN      = 16'd60;
    localparam logic [TIMER_W-1:0] LEARN_MAX      = 16'd3600;
    localparam logic [COUNT_W-1:0] HOLD_MAX       = 8'd255;

    localparam logic [COUNT_W-1:0] RST_DEBOUNCE   = 8'd3;
    localparam logic [TIMER_W-1:0] RST_WASH_WAIT  = 16'd10;
    localparam logic [TIMER_W-1:0] RST_WASH_SHORT = 16'd30;
    localparam logic [TIMER_W-1:0] RST_WASH_LONG  = 16'd99;
    localparam logic [COUNT_W-1:0] RST_HOLD_THR   = 8'd21;
    localparam logic [TIMER_W-1:0] RST_DRY_WAIT   = 16'd180;
    localparam logic [TIMER_W-1:0] RST_INT_WORK   = 16'd30;
    localparam logic [WAIT_W-1:0]  RST_INT_WAIT   = 12'd210;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 3'd0,
        CFG_WASH_WAIT  = 3'd1,
        CFG_WASH_SHORT = 3'd2,
        CFG_WASH_LONG  = 3'd3,
        CFG_HOLD_THR   = 3'd4,
        CFG_DRY_WAIT   = 3'd5,
        CFG_INT_WORK   = 3'd6,
        CFG_INT_WAIT   = 3'd7
    } t_cfg_idx;

endpackage

`default_nettype wire

>>> sv/wiper_interval_controller.sv
// Wiper interval controller. Each accepted input request is one tick carrying the
// raw, active-low washer and intermittent switch levels; each produces exactly one
// result request with the motor relay and washing flags as they stand after that
// tick. Both switches are debounced by debounce_ticks, intermittent mode learns
// its pause from the idle time between wipes (falling back to
// interval_default_wait outside 60..3600 ticks), and washer mode gives a short
// or long wipe plus an optional drying wipe. The whole state update is one
// combinational pass into the state registers, and the result sits in an output
// register, so a new tick is taken every cycle unless the output register is full
// and stalled. Configuration writes take effect on the next edge and should only
// be made while the block is idle.
`default_nettype none

module wiper_interval_controller
    import wic_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_washer_pin,
    input  wire logic                  i_interval_pin,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_wiper_run,
    output logic                       o_washing
);

    // configuration
    logic [COUNT_W-1:0] r_debounce_ticks;
    logic [TIMER_W-1:0] r_wash_wait_time;
    logic [TIMER_W-1:0] r_wash_work_short;
    logic [TIMER_W-1:0] r_wash_work_long;
    logic [COUNT_W-1:0] r_hold_threshold;
    logic [TIMER_W-1:0] r_drying_wait_time;
    logic [TIMER_W-1:0] r_interval_work_time;
    logic [WAIT_W-1:0]  r_interval_default_wait;

    // wiper state
    logic               r_wash_mode,         n_wash_mode;
    logic               r_drying_pending,    n_drying_pending;
    logic               r_drying_wait,       n_drying_wait;
    logic               r_working,           n_working;
    logic [COUNT_W-1:0] r_interval_debounce, n_interval_debounce;
    logic [COUNT_W-1:0] r_washer_debounce,   n_washer_debounce;
    logic               r_interval_level,    n_interval_level;
    logic               r_washer_level,      n_washer_level;
    logic [TIMER_W-1:0] r_phase_timer,       n_phase_timer;
    logic [TIMER_W-1:0] r_phase_wait_limit,  n_phase_wait_limit;
    logic [TIMER_W-1:0] r_phase_work_limit,  n_phase_work_limit;
    logic [COUNT_W-1:0] r_hold_timer,        n_hold_timer;
    logic [TIMER_W-1:0] r_idle_timer,        n_idle_timer;
    logic [WAIT_W-1:0]  r_learned_wait,      n_learned_wait;

    // result register
    logic r_out_valid;
    logic r_wiper_run;
    logic r_washing;

    logic in_fire;
    logic out_fire;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_wiper_run = r_wiper_run;
    assign o_washing   = r_washing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks        <= RST_DEBOUNCE;
            r_wash_wait_time        <= RST_WASH_WAIT;
            r_wash_work_short       <= RST_WASH_SHORT;
            r_wash_work_long        <= RST_WASH_LONG;
            r_hold_threshold        <= RST_HOLD_THR;
            r_drying_wait_time      <= RST_DRY_WAIT;
            r_interval_work_time    <= RST_INT_WORK;
            r_interval_default_wait <= RST_INT_WAIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DEBOUNCE:   r_debounce_ticks        <= i_cfg_wdata[COUNT_W-1:0];
                CFG_WASH_WAIT:  r_wash_wait_time        <= i_cfg_wdata[TIMER_W-1:0];
                CFG_WASH_SHORT: r_wash_work_short       <= i_cfg_wdata[TIMER_W-1:0];
                CFG_WASH_LONG:  r_wash_work_long        <= i_cfg_wdata[TIMER_W-1:0];
                CFG_HOLD_THR:   r_hold_threshold        <= i_cfg_wdata[COUNT_W-1:0];
                CFG_DRY_WAIT:   r_drying_wait_time      <= i_cfg_wdata[TIMER_W-1:0];
                CFG_INT_WORK:   r_interval_work_time    <= i_cfg_wdata[TIMER_W-1:0];
                CFG_INT_WAIT:   r_interval_default_wait <= i_cfg_wdata[WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic may_restart;

        n_wash_mode         = r_wash_mode;
        n_drying_pending    = r_drying_pending;
        n_drying_wait       = r_drying_wait;
        n_working           = r_working;
        n_interval_debounce = r_interval_debounce;
        n_washer_debounce   = r_washer_debounce;
        n_interval_level    = r_interval_level;
        n_washer_level      = r_washer_level;
        n_phase_timer       = r_phase_timer;
        n_phase_wait_limit  = r_phase_wait_limit;
        n_phase_work_limit  = r_phase_work_limit;
        n_hold_timer        = r_hold_timer;
        n_idle_timer        = r_idle_timer;
        n_learned_wait      = r_learned_wait;
        may_restart         = 1'b0;

        // intermittent switch
        if (n_interval_debounce == '0) begin
            if (i_interval_pin != n_interval_level) begin
                n_interval_debounce = r_debounce_ticks;
            end
        end else begin
            if (n_interval_debounce == COUNT_W'(1) && i_interval_pin != n_interval_level) begin
                n_interval_level = i_interval_pin;
                if (!n_interval_level) begin
                    if (n_idle_timer < LEARN_MIN || n_idle_timer > LEARN_MAX) begin
                        n_learned_wait = r_interval_default_wait;
                    end else begin
                        n_learned_wait = n_idle_timer[WAIT_W-1:0];
                    end
                    may_restart = !n_wash_mode || (n_drying_wait && !n_working);
                    if (may_restart) begin
                        n_working          = 1'b1;
                        n_phase_timer      = '0;
                        n_phase_wait_limit = TIMER_W'(n_learned_wait);
                        n_phase_work_limit = r_interval_work_time;
                    end
                end
            end
            n_interval_debounce = n_interval_debounce - COUNT_W'(1);
        end

        // washer switch
        if (n_washer_debounce == '0) begin
            if (i_washer_pin != n_washer_level) begin
                n_washer_debounce = r_debounce_ticks;
            end
        end else begin
            if (n_washer_debounce == COUNT_W'(1) && i_washer_pin != n_washer_level) begin
                n_washer_level = i_washer_pin;
                if (!n_washer_level) begin
                    may_restart = !n_wash_mode || (n_drying_wait && !n_working);
                    if (may_restart) begin
                        n_wash_mode        = 1'b1;
                        n_drying_pending   = 1'b0;
                        n_drying_wait      = 1'b0;
                        n_working          = 1'b0;
                        n_phase_timer      = '0;
                        n_hold_timer       = '0;
                        n_phase_wait_limit = r_wash_wait_time;
                        n_phase_work_limit = r_wash_work_short;
                    end else begin
                        n_phase_work_limit = r_wash_work_long;
                        if (n_interval_level
                            || TIMER_W'(n_learned_wait) > r_drying_wait_time) begin
                            n_drying_pending = 1'b1;
                        end
                    end
                end else if (n_hold_timer > r_hold_threshold) begin
                    // release after a long hold
                    n_phase_timer      = '0;
                    n_phase_work_limit = r_wash_work_long;
                    if (n_interval_level
                        || TIMER_W'(n_learned_wait) > r_drying_wait_time) begin
                        n_drying_pending = 1'b1;
                    end
                end
            end
            n_washer_debounce = n_washer_debounce - COUNT_W'(1);
        end

        // hold timer
        if (!n_washer_level && n_hold_timer < HOLD_MAX) begin
            n_hold_timer = n_hold_timer + COUNT_W'(1);
        end

        // wiper phases
        if (n_phase_timer < TIMER_IDLE) begin
            if (!n_working) begin
                if (n_phase_timer >= n_phase_wait_limit) begin
                    if (!n_interval_level || n_wash_mode) begin
                        n_working     = 1'b1;
                        n_phase_timer = '0;
                    end else begin
                        n_phase_timer = TIMER_IDLE;
                    end
                end
            end else if (n_phase_timer >= n_phase_work_limit) begin
                if (!n_washer_level) begin
                    n_phase_timer = '0;
                end else begin
                    if (n_wash_mode) begin
                        if (n_drying_pending) begin
                            n_drying_pending   = 1'b0;
                            n_drying_wait      = 1'b1;
                            n_phase_wait_limit = r_drying_wait_time;
                            n_phase_work_limit = r_wash_work_short;
                            n_phase_timer      = '0;
                        end else begin
                            n_wash_mode   = 1'b0;
                            n_drying_wait = 1'b0;
                        end
                    end
                    if (!n_wash_mode) begin
                        if (!n_interval_level) begin
                            n_phase_timer      = '0;
                            n_phase_wait_limit = TIMER_W'(n_learned_wait);
                            n_phase_work_limit = r_interval_work_time;
                        end else begin
                            n_phase_timer = TIMER_IDLE;
                        end
                    end
                    n_working    = 1'b0;
                    n_idle_timer = '0;
                end
            end
            if (n_phase_timer < TIMER_IDLE) begin
                n_phase_timer = n_phase_timer + TIMER_W'(1);
            end
        end

        // idle timer
        if (!n_working && n_idle_timer < TIMER_IDLE) begin
            n_idle_timer = n_idle_timer + TIMER_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wash_mode         <= 1'b0;
            r_drying_pending    <= 1'b0;
            r_drying_wait       <= 1'b0;
            r_working           <= 1'b0;
            r_interval_debounce <= '0;
            r_washer_debounce   <= '0;
            r_interval_level    <= 1'b1;
            r_washer_level      <= 1'b1;
            r_phase_timer       <= TIMER_IDLE;
            r_phase_wait_limit  <= '0;
            r_phase_work_limit  <= '0;
            r_hold_timer        <= '0;
            r_idle_timer        <= TIMER_IDLE;
            r_learned_wait      <= RST_INT_WAIT;
        end else if (in_fire) begin
            r_wash_mode         <= n_wash_mode;
            r_drying_pending    <= n_drying_pending;
            r_drying_wait       <= n_drying_wait;
            r_working           <= n_working;
            r_interval_debounce <= n_interval_debounce;
            r_washer_debounce   <= n_washer_debounce;
            r_interval_level    <= n_interval_level;
            r_washer_level      <= n_washer_level;
            r_phase_timer       <= n_phase_timer;
            r_phase_wait_limit  <= n_phase_wait_limit;
            r_phase_work_limit  <= n_phase_work_limit;
            r_hold_timer        <= n_hold_timer;
            r_idle_timer        <= n_idle_timer;
            r_learned_wait      <= n_learned_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_wiper_run <= n_working;
            r_washing   <= n_wash_mode;
        end
    end

`include "assert_macros.svh"

    `WIC_ASSERT_ALWAYS(a_phase_sat, i_clk, i_rst_n, r_phase_timer <= TIMER_IDLE, "phase timer past idle marker")
    `WIC_ASSERT_ALWAYS(a_idle_sat, i_clk, i_rst_n, r_idle_timer <= TIMER_IDLE, "idle timer past idle marker")
    `WIC_ASSERT_ALWAYS(a_dry_in_wash, i_clk, i_rst_n, !r_drying_wait || r_wash_mode, "drying wait outside wash mode")
    `WIC_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_fire, r_out_valid && r_wiper_run == r_working && r_washing == r_wash_mode, "result does not match state")

endmodule

`default_nettype wire
